// ===== hdl/assc_pkg.sv =====
// ----------------------------------------------------------------------------
// assc_pkg: shared types and constants of the adaptive step size controller
// Item structs, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package assc_pkg;

    localparam int RETRY_LIMIT_DEF     = 10;
    localparam int ROOT_ITERATIONS_DEF = 32;

    // configuration register indexes
    localparam logic [2:0] REG_TOLERANCE  = 3'd0;
    localparam logic [2:0] REG_RATIO_MAX  = 3'd1;
    localparam logic [2:0] REG_RATIO_MIN  = 3'd2;
    localparam logic [2:0] REG_SCALE      = 3'd3;
    localparam logic [2:0] REG_STEP_MAX   = 3'd4;
    localparam logic [2:0] REG_STEP_MIN   = 3'd5;
    localparam logic [2:0] REG_INIT_STEP  = 3'd6;
    localparam logic [2:0] REG_DIV_ACTION = 3'd7;

    // register reset values
    localparam logic [31:0] TOLERANCE_RST  = 32'd65536;
    localparam logic [20:0] RATIO_MAX_RST  = 21'd131072;
    localparam logic [20:0] RATIO_MIN_RST  = 21'd32768;
    localparam logic [16:0] SCALE_RST      = 17'd58982;
    localparam logic [31:0] STEP_MAX_RST   = 32'd65536;
    localparam logic [31:0] STEP_MIN_RST   = 32'd1;
    localparam logic [31:0] INIT_STEP_RST  = 32'd655;

    // divergence actions
    localparam logic [1:0] ACT_HALVE    = 2'd0;
    localparam logic [1:0] ACT_CONTINUE = 2'd1;
    localparam logic [1:0] ACT_STOP     = 2'd2;

    localparam logic CMD_CONVERGED = 1'b0;
    localparam logic CMD_DIVERGED  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] error_norm;
        logic [2:0]  method_order;
    } in_item_t;

    typedef struct packed {
        logic        step_accepted;
        logic        forced_advance;
        logic        halted;
        logic [31:0] next_step_size;
        logic [3:0]  retries_used;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RCAND,
        ST_RMUL,
        ST_SCALE,
        ST_NSTEP,
        ST_HIB,
        ST_LOB,
        ST_LIMIT,
        ST_FIN
    } assc_state_t;

endpackage

`default_nettype wire

// ===== hdl/adaptive_step_size_controller_unit.sv =====
// ----------------------------------------------------------------------------
// adaptive_step_size_controller_unit: step size proposal for a time integrator
// Tolerance check, (order+1)-th root of tol/norm, ratio and absolute banding.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A converged item with a nonzero norm runs
// through the restoring divider (one quotient bit a cycle), then through the
// root search over ROOT_ITERATIONS bits (32 by default), where every trial
// power runs through a 64 x 16 digit-serial multiplier at three digits a
// product, then through four more products, the absolute band and hand-over.
// A zero norm skips the divider and the root; halving and stop items go
// straight to hand-over. A finished result sits in an output register, so the
// next item is taken while it waits.
`default_nettype none

module adaptive_step_size_controller_unit #(
    parameter int RETRY_LIMIT     = assc_pkg::RETRY_LIMIT_DEF,
    parameter int ROOT_ITERATIONS = assc_pkg::ROOT_ITERATIONS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  assc_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output assc_pkg::out_item_t  m_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [2:0]            cfg_index,
    input  wire [31:0]           cfg_wdata
);

    localparam int IW = $clog2(ROOT_ITERATIONS);

    // configuration
    logic [31:0] tol_reg, step_max_reg, step_min_reg;
    logic [20:0] ratio_max_reg, ratio_min_reg;
    logic [16:0] scale_reg;
    logic [1:0]  action_reg;

    // controller state
    logic [31:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [3:0]  retry_reg, retry_next;

    assc_pkg::assc_state_t state_reg, state_next;

    // working registers
    logic [31:0] norm_reg, norm_next;
    logic [2:0]  order_reg, order_next;
    logic        acc_reg, acc_next, halt_reg, halt_next, hit_reg, hit_next;
    logic [63:0] div_reg, div_next;
    logic [32:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] root_reg, root_next, cand_reg, cand_next, bit_reg, bit_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic [2:0]  jcnt_reg, jcnt_next;
    logic [63:0] n_reg, n_next;

    // digit-serial multiplier
    logic [63:0] mul_a_reg, mul_a_next;
    logic [47:0] mul_b_reg, mul_b_next;
    logic [63:0] acc_hi_reg, acc_hi_next;
    logic [47:0] acc_lo_reg, acc_lo_next;
    logic [1:0]  dig_reg, dig_next;

    logic        m_valid_reg, m_valid_next;
    assc_pkg::out_item_t out_reg, out_next;

    // combinational helpers
    logic [79:0] mul_pp, mul_sum;
    logic [63:0] prod_hi;
    logic [47:0] prod_lo;
    logic        mul_last;
    logic [63:0] pw_new, mid_val;
    logic [32:0] div_shift;
    logic        div_ge;
    logic [47:0] cand_now, root_upd;
    logic        keep;
    logic [3:0]  attempts;

    assign s_ready   = (state_reg == assc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign mul_pp   = {16'b0, mul_a_reg} * {64'b0, mul_b_reg[15:0]};
    assign mul_sum  = {16'b0, acc_hi_reg} + mul_pp;
    assign prod_hi  = mul_sum[79:16];
    assign prod_lo  = {mul_sum[15:0], acc_lo_reg[47:16]};
    assign mul_last = (dig_reg == 2'd2);
    // product >> 32 and product >> 16, both as 64 bits
    assign pw_new   = {prod_hi[47:0], prod_lo[47:32]};
    assign mid_val  = {prod_hi[31:0], prod_lo[47:16]};

    assign div_shift = {rem_reg[31:0], div_reg[63]};
    assign div_ge    = (div_shift >= {1'b0, norm_reg});
    assign cand_now  = root_reg | bit_reg;
    assign attempts  = retry_reg + 4'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg       <= assc_pkg::TOLERANCE_RST;
            ratio_max_reg <= assc_pkg::RATIO_MAX_RST;
            ratio_min_reg <= assc_pkg::RATIO_MIN_RST;
            scale_reg     <= assc_pkg::SCALE_RST;
            step_max_reg  <= assc_pkg::STEP_MAX_RST;
            step_min_reg  <= assc_pkg::STEP_MIN_RST;
            action_reg    <= assc_pkg::ACT_HALVE;
        end else if (cfg_valid) begin
            case (cfg_index)
                assc_pkg::REG_TOLERANCE:  tol_reg       <= cfg_wdata;
                assc_pkg::REG_RATIO_MAX:  ratio_max_reg <= cfg_wdata[20:0];
                assc_pkg::REG_RATIO_MIN:  ratio_min_reg <= cfg_wdata[20:0];
                assc_pkg::REG_SCALE:      scale_reg     <= cfg_wdata[16:0];
                assc_pkg::REG_STEP_MAX:   step_max_reg  <= cfg_wdata;
                assc_pkg::REG_STEP_MIN:   step_min_reg  <= cfg_wdata;
                // the step state only takes the initial step at reset
                assc_pkg::REG_INIT_STEP:  ;
                assc_pkg::REG_DIV_ACTION: action_reg    <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= assc_pkg::ST_IDLE;
            cur_reg     <= assc_pkg::INIT_STEP_RST;
            prev_reg    <= assc_pkg::INIT_STEP_RST;
            retry_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            retry_reg   <= retry_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        norm_reg   <= norm_next;
        order_reg  <= order_next;
        acc_reg    <= acc_next;
        halt_reg   <= halt_next;
        hit_reg    <= hit_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        root_reg   <= root_next;
        cand_reg   <= cand_next;
        bit_reg    <= bit_next;
        iter_reg   <= iter_next;
        jcnt_reg   <= jcnt_next;
        n_reg      <= n_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        acc_hi_reg <= acc_hi_next;
        acc_lo_reg <= acc_lo_next;
        dig_reg    <= dig_next;
        out_reg    <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        retry_next   = retry_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        norm_next    = norm_reg;
        order_next   = order_reg;
        acc_next     = acc_reg;
        halt_next    = halt_reg;
        hit_next     = hit_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        root_next    = root_reg;
        cand_next    = cand_reg;
        bit_next     = bit_reg;
        iter_next    = iter_reg;
        jcnt_next    = jcnt_reg;
        n_next       = n_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        acc_hi_next  = acc_hi_reg;
        acc_lo_next  = acc_lo_reg;
        dig_next     = dig_reg;
        keep         = 1'b0;
        root_upd     = root_reg;

        // advance the multiplier one digit in every product state
        if (state_reg inside {assc_pkg::ST_RMUL, assc_pkg::ST_SCALE, assc_pkg::ST_NSTEP,
                              assc_pkg::ST_HIB, assc_pkg::ST_LOB}) begin
            acc_hi_next = prod_hi;
            acc_lo_next = prod_lo;
            mul_b_next  = {16'b0, mul_b_reg[47:16]};
            dig_next    = dig_reg + 2'd1;
        end

        case (state_reg)
            assc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    norm_next  = s_data.error_norm;
                    order_next = s_data.method_order;
                    halt_next  = 1'b0;
                    acc_next   = 1'b0;
                    if (s_data.command == assc_pkg::CMD_DIVERGED &&
                        action_reg >= assc_pkg::ACT_STOP) begin
                        halt_next  = 1'b1;
                        state_next = assc_pkg::ST_FIN;
                    end else if (s_data.command == assc_pkg::CMD_DIVERGED &&
                                 action_reg == assc_pkg::ACT_HALVE) begin
                        n_next     = {33'b0, cur_reg[31:1]};
                        state_next = assc_pkg::ST_FIN;
                    end else begin
                        acc_next = (s_data.error_norm < tol_reg);
                        if (s_data.error_norm == '0) begin
                            mul_a_next  = {43'b0, ratio_max_reg};
                            mul_b_next  = {16'b0, cur_reg};
                            acc_hi_next = '0;
                            acc_lo_next = '0;
                            dig_next    = '0;
                            state_next  = assc_pkg::ST_NSTEP;
                        end else begin
                            div_next   = {tol_reg, 32'b0};
                            rem_next   = '0;
                            cnt_next   = '0;
                            state_next = assc_pkg::ST_DIV;
                        end
                    end
                end
            end
            assc_pkg::ST_DIV: begin
                rem_next = div_ge ? (div_shift - {1'b0, norm_reg}) : div_shift;
                div_next = {div_reg[62:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    root_next  = '0;
                    bit_next   = {1'b1, 47'b0};
                    iter_next  = '0;
                    state_next = assc_pkg::ST_RCAND;
                end
            end
            assc_pkg::ST_RCAND: begin
                cand_next = cand_now;
                if (order_reg == '0) begin
                    keep = ({16'b0, cand_now} <= div_reg);
                end else begin
                    mul_a_next  = {16'b0, cand_now};
                    mul_b_next  = cand_now;
                    acc_hi_next = '0;
                    acc_lo_next = '0;
                    dig_next    = '0;
                    jcnt_next   = 3'd1;
                    state_next  = assc_pkg::ST_RMUL;
                end
            end
            assc_pkg::ST_RMUL: begin
                if (mul_last) begin
                    if (prod_hi[63:48] != '0) begin
                        keep = 1'b0;
                    end else if (jcnt_reg == order_reg) begin
                        keep = (pw_new <= div_reg);
                    end else begin
                        jcnt_next   = jcnt_reg + 3'd1;
                        mul_a_next  = pw_new;
                        mul_b_next  = cand_reg;
                        acc_hi_next = '0;
                        acc_lo_next = '0;
                        dig_next    = '0;
                    end
                end
            end
            assc_pkg::ST_SCALE: begin
                if (mul_last) begin
                    mul_a_next  = {16'b0, pw_new[47:0]};
                    mul_b_next  = {16'b0, cur_reg};
                    acc_hi_next = '0;
                    acc_lo_next = '0;
                    dig_next    = '0;
                    state_next  = assc_pkg::ST_NSTEP;
                end
            end
            assc_pkg::ST_NSTEP: begin
                if (mul_last) begin
                    n_next      = (prod_hi[63:32] != '0) ? '1 : mid_val;
                    mul_a_next  = {43'b0, ratio_max_reg};
                    mul_b_next  = {16'b0, prev_reg};
                    acc_hi_next = '0;
                    acc_lo_next = '0;
                    dig_next    = '0;
                    state_next  = assc_pkg::ST_HIB;
                end
            end
            assc_pkg::ST_HIB: begin
                if (mul_last) begin
                    hit_next = (n_reg > mid_val);
                    if (n_reg > mid_val) begin
                        n_next = mid_val;
                    end
                    mul_a_next  = {43'b0, ratio_min_reg};
                    mul_b_next  = {16'b0, prev_reg};
                    acc_hi_next = '0;
                    acc_lo_next = '0;
                    dig_next    = '0;
                    state_next  = assc_pkg::ST_LOB;
                end
            end
            assc_pkg::ST_LOB: begin
                if (mul_last) begin
                    if (!hit_reg && n_reg < mid_val) begin
                        n_next = mid_val;
                    end
                    state_next = assc_pkg::ST_LIMIT;
                end
            end
            assc_pkg::ST_LIMIT: begin
                if (n_reg > {32'b0, step_max_reg}) begin
                    n_next = {32'b0, step_max_reg};
                end else if (n_reg < {32'b0, step_min_reg}) begin
                    n_next = {32'b0, step_min_reg};
                end
                state_next = assc_pkg::ST_FIN;
            end
            assc_pkg::ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = assc_pkg::ST_IDLE;
                    if (halt_reg) begin
                        out_next.step_accepted  = 1'b0;
                        out_next.forced_advance = 1'b0;
                        out_next.halted         = 1'b1;
                        out_next.next_step_size = cur_reg;
                        out_next.retries_used   = retry_reg;
                    end else begin
                        out_next.step_accepted  = acc_reg;
                        out_next.forced_advance = !acc_reg &&
                                                  (attempts >= 4'(RETRY_LIMIT));
                        out_next.halted         = 1'b0;
                        out_next.next_step_size = n_reg[31:0];
                        out_next.retries_used   = attempts;
                        cur_next = n_reg[31:0];
                        if (acc_reg) begin
                            prev_next  = cur_reg;
                            retry_next = '0;
                        end else if (attempts >= 4'(RETRY_LIMIT)) begin
                            prev_next  = n_reg[31:0];
                            retry_next = '0;
                        end else begin
                            retry_next = attempts;
                        end
                    end
                end
            end
            default: state_next = assc_pkg::ST_IDLE;
        endcase

        // close one root bit: keep or drop it, then move to the next
        if ((state_reg == assc_pkg::ST_RCAND && order_reg == '0) ||
            (state_reg == assc_pkg::ST_RMUL && mul_last &&
             (prod_hi[63:48] != '0 || jcnt_reg == order_reg))) begin
            if (keep) begin
                root_upd = (state_reg == assc_pkg::ST_RCAND) ? cand_now : cand_reg;
            end
            root_next = root_upd;
            bit_next  = {1'b0, bit_reg[47:1]};
            iter_next = iter_reg + IW'(1);
            if (iter_reg == IW'(ROOT_ITERATIONS - 1)) begin
                mul_a_next  = {16'b0, root_upd};
                mul_b_next  = {31'b0, scale_reg};
                acc_hi_next = '0;
                acc_lo_next = '0;
                dig_next    = '0;
                state_next  = assc_pkg::ST_SCALE;
            end else begin
                state_next = assc_pkg::ST_RCAND;
            end
        end
    end

    a_retry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        retry_reg < 4'(RETRY_LIMIT))
        else $error("retry count reached the limit without clearing");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == assc_pkg::ST_FIN))
        else $error("result raised outside the hand-over state");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == assc_pkg::ST_DIV) |=> (rem_reg < {1'b0, norm_reg}))
        else $error("divider remainder not below the norm");

    a_power_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == assc_pkg::ST_RMUL) |-> (jcnt_reg != '0 && jcnt_reg <= order_reg))
        else $error("root power count out of range");

endmodule

`default_nettype wire
